// ===== hw/rtl/soil_workability_sowing_day_top_macros.svh =====
// Assertion macros for the RTL of the sowing-day block.
// The checks are compiled out when SYNTHESIS is defined.
`ifndef SOIL_WORKABILITY_SOWING_DAY_TOP_MACROS_SVH
`define SOIL_WORKABILITY_SOWING_DAY_TOP_MACROS_SVH

`ifndef SYNTHESIS
`define SWSD_ASSERT(name, prop) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error("check failed");
`define SWSD_ASSERT_ALWAYS(name, prop) \
  name: assert property (@(posedge clk) prop) else $error("check failed");
`else
`define SWSD_ASSERT(name, prop)
`define SWSD_ASSERT_ALWAYS(name, prop)
`endif

`endif

// ===== hw/rtl/swsd_pkg.sv =====
package swsd_pkg;

  localparam int FRAC_BITS   = 12;
  localparam int RISE_POINTS = 5;
  localparam int SEGS        = RISE_POINTS - 1;
  localparam int ONE_FX      = 1 << FRAC_BITS;

  // Capillary rise table in hundredths of a cm: deficit and rise.
  typedef int tab_t [RISE_POINTS];
  typedef int seg_tab_t [SEGS];
  typedef longint rec_tab_t [SEGS];

  localparam tab_t RISE_X_HUND = '{-50, 0, 10, 40, 100};
  localparam tab_t RISE_Y_HUND = '{50, 20, 15, 10, 5};

  // Round to the nearest fixed-point step, halves away from zero.
  function automatic int scale_hund(int v);
    int a;
    int r;
    a = (v < 0) ? -v : v;
    r = (a * ONE_FX + 50) / 100;
    return (v < 0) ? -r : r;
  endfunction

  function automatic tab_t scale_tab(tab_t h);
    tab_t t;
    for (int i = 0; i < RISE_POINTS; i++) t[i] = scale_hund(h[i]);
    return t;
  endfunction

  localparam tab_t RISE_X = scale_tab(RISE_X_HUND);
  localparam tab_t RISE_Y = scale_tab(RISE_Y_HUND);

  // Per-segment span, rise step magnitude and slope direction. A segment
  // whose span is not positive holds its left value.
  function automatic seg_tab_t seg_d_tab();
    seg_tab_t t;
    int d;
    for (int i = 0; i < SEGS; i++) begin
      d = RISE_X[i+1] - RISE_X[i];
      t[i] = (d > 0) ? d : 1;
    end
    return t;
  endfunction

  function automatic seg_tab_t seg_dy_tab();
    seg_tab_t t;
    int d;
    int dy;
    for (int i = 0; i < SEGS; i++) begin
      d = RISE_X[i+1] - RISE_X[i];
      dy = RISE_Y[i+1] - RISE_Y[i];
      t[i] = (d <= 0) ? 0 : ((dy < 0) ? -dy : dy);
    end
    return t;
  endfunction

  function automatic seg_tab_t seg_neg_tab();
    seg_tab_t t;
    for (int i = 0; i < SEGS; i++) t[i] = (RISE_Y[i+1] < RISE_Y[i]) ? 1 : 0;
    return t;
  endfunction

  localparam seg_tab_t SEG_D   = seg_d_tab();
  localparam seg_tab_t SEG_DY  = seg_dy_tab();
  localparam seg_tab_t SEG_NEG = seg_neg_tab();

  function automatic int max_d();
    int m;
    m = 1;
    for (int i = 0; i < SEGS; i++) if (SEG_D[i] > m) m = SEG_D[i];
    return m;
  endfunction

  function automatic int max_dy();
    int m;
    m = 0;
    for (int i = 0; i < SEGS; i++) if (SEG_DY[i] > m) m = SEG_DY[i];
    return m;
  endfunction

  function automatic int max_y();
    int m;
    m = 0;
    for (int i = 0; i < RISE_POINTS; i++) if (RISE_Y[i] > m) m = RISE_Y[i];
    return m;
  endfunction

  // Upper bound on the dividend of the interpolation, rounding bias included.
  function automatic longint max_num();
    longint m;
    longint v;
    m = 0;
    for (int i = 0; i < SEGS; i++) begin
      v = longint'(SEG_D[i]) * longint'(SEG_DY[i]) + longint'(SEG_D[i]);
      if (v > m) m = v;
    end
    return m;
  endfunction

  localparam int X_W       = FRAC_BITS + 2;
  localparam int Y_W       = $clog2(max_y() + 2);
  localparam int DX_W      = $clog2(max_d() + 1);
  localparam int DY_W      = $clog2(max_dy() + 2);
  localparam int NUM_W     = $clog2(max_num() + 2);
  localparam int DIV_SHIFT = NUM_W + $clog2(max_d());

  // Reciprocal that makes (n * r) >> DIV_SHIFT an exact floor of n / d for
  // every dividend below 2**NUM_W.
  function automatic longint seg_recip(int i);
    return ((longint'(1) <<< DIV_SHIFT) + longint'(SEG_D[i]) - 1) / SEG_D[i];
  endfunction

  function automatic rec_tab_t recip_tab();
    rec_tab_t t;
    for (int i = 0; i < SEGS; i++) t[i] = seg_recip(i);
    return t;
  endfunction

  localparam rec_tab_t SEG_RECIP = recip_tab();

  function automatic longint max_recip();
    longint m;
    m = 1;
    for (int i = 0; i < SEGS; i++) if (SEG_RECIP[i] > m) m = SEG_RECIP[i];
    return m;
  endfunction

  localparam int REC_W = $clog2(max_recip() + 1);
  localparam int MUL_W = 32;

  localparam int REG_COUNT  = 5;
  localparam int CFG_ADDR_W = $clog2(REG_COUNT) + 2;

  typedef enum logic [CFG_ADDR_W-3:0] {
    REG_SEEP_SLOPE    = 0,
    REG_SEEP_OFFSET   = 1,
    REG_DEFICIT_LIMIT = 2,
    REG_EARLIEST_DAY  = 3,
    REG_LATEST_DAY    = 4
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INTERP,
    ST_DIVIDE,
    ST_EVAP,
    ST_UPDATE,
    ST_SEEP_MUL,
    ST_SEEP,
    ST_DONE
  } seq_state_t;

  typedef struct packed {
    logic [15:0] day_index;
    logic [17:0] rainfall;
    logic [17:0] potential_evap;
  } day_beat_t;

  typedef struct packed {
    logic [17:0]        soil_evap;
    logic [30:0]        seepage;
    logic signed [31:0] excess_water;
    logic [7:0]         workable_run;
    logic               sow_now;
    logic               sown_at_latest;
  } res_beat_t;

  typedef struct packed {
    logic [12:0]        seep_slope;
    logic [12:0]        seep_offset;
    logic signed [14:0] deficit_limit;
    logic [15:0]        earliest_sow_day;
    logic [15:0]        latest_sow_day;
  } cfg_regs_t;

  typedef struct packed {
    logic [Y_W-1:0]   y0;
    logic [DX_W-1:0]  dx;
    logic [DY_W-1:0]  dy;
    logic             neg;
    logic [DX_W-1:0]  d_adj;
    logic [REC_W-1:0] recip;
  } rise_seg_t;

endpackage

// ===== hw/rtl/swsd_cfg.sv =====
module swsd_cfg (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [swsd_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready,
  output swsd_pkg::cfg_regs_t               cfg
);
  import swsd_pkg::*;

  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[CFG_ADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.seep_slope       <= 13'd3686;
      cfg.seep_offset      <= 13'd287;
      cfg.deficit_limit    <= 15'sd0;
      cfg.earliest_sow_day <= 16'd0;
      cfg.latest_sow_day   <= 16'd15;
    end else if (wr_en) begin
      unique case (idx)
        REG_SEEP_SLOPE:    cfg.seep_slope       <= pwdata[12:0];
        REG_SEEP_OFFSET:   cfg.seep_offset      <= pwdata[12:0];
        REG_DEFICIT_LIMIT: cfg.deficit_limit    <= pwdata[14:0];
        REG_EARLIEST_DAY:  cfg.earliest_sow_day <= pwdata[15:0];
        REG_LATEST_DAY:    cfg.latest_sow_day   <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_SEEP_SLOPE:    prdata = 32'(cfg.seep_slope);
      REG_SEEP_OFFSET:   prdata = 32'(cfg.seep_offset);
      REG_DEFICIT_LIMIT: prdata = 32'(cfg.deficit_limit);
      REG_EARLIEST_DAY:  prdata = 32'(cfg.earliest_sow_day);
      REG_LATEST_DAY:    prdata = 32'(cfg.latest_sow_day);
      default:           prdata = '0;
    endcase
  end

endmodule

// ===== hw/rtl/swsd_rise.sv =====
module swsd_rise (
  input  logic                             clk,
  input  logic                             load,
  input  logic signed [swsd_pkg::X_W-1:0]  x,
  output swsd_pkg::rise_seg_t              seg
);
  import swsd_pkg::*;

  rise_seg_t seg_next;

  // Outside the table the end value is held; that is a segment with a zero
  // offset, so the later multiply and divide passes return zero.
  always_comb begin
    seg_next.y0    = Y_W'(RISE_Y[RISE_POINTS-1]);
    seg_next.dx    = '0;
    seg_next.dy    = '0;
    seg_next.neg   = 1'b0;
    seg_next.d_adj = '0;
    seg_next.recip = '0;
    if (x <= X_W'(RISE_X[0])) begin
      seg_next.y0 = Y_W'(RISE_Y[0]);
    end else begin
      // Walk down so that the lowest segment whose right end lies above x wins.
      for (int i = SEGS - 1; i >= 0; i--) begin
        if (x < X_W'(RISE_X[i+1])) begin
          seg_next.y0    = Y_W'(RISE_Y[i]);
          seg_next.dx    = DX_W'(x - X_W'(RISE_X[i]));
          seg_next.dy    = DY_W'(SEG_DY[i]);
          seg_next.neg   = (SEG_NEG[i] != 0);
          seg_next.d_adj = DX_W'(SEG_D[i] - 1);
          seg_next.recip = REC_W'(SEG_RECIP[i]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      seg <= seg_next;
    end
  end

endmodule

// ===== hw/rtl/swsd_mul.sv =====
module swsd_mul (
  input  logic                            clk,
  input  logic [swsd_pkg::MUL_W-1:0]      a,
  input  logic [swsd_pkg::MUL_W-1:0]      b,
  output logic [2*swsd_pkg::MUL_W-1:0]    p
);
  import swsd_pkg::*;

  always_ff @(posedge clk) begin
    p <= (2*MUL_W)'(a) * (2*MUL_W)'(b);
  end

endmodule

// ===== hw/rtl/soil_workability_sowing_day_top.sv =====
// Plow-layer water balance and sowing-day detector. Each day beat carries
// the day index, rain and potential soil evaporation in cm with 12 fraction
// bits; the block updates its excess-water store and workable-day run and
// returns one result beat per day. A day beat is accepted only while the
// sequencer is idle: its result is loaded into the output register after the
// interpolation, divide, evaporation, update, seepage-multiply and seepage
// states, once no stalled result holds it, and the next day can be taken in
// the following cycle. The steps follow the one 32x32 multiplier, which is
// used three times per day (interpolation product, reciprocal division of
// the capillary-rise slope, seepage product), with the adds and clamps
// between those passes. There is no clearing pass after reset. Configuration
// is by the APB port: seep slope at 0x0, seep offset at 0x4, deficit limit
// at 0x8, earliest sowing day at 0xC and latest sowing day at 0x10.
`include "soil_workability_sowing_day_top_macros.svh"

module soil_workability_sowing_day_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              day_valid,
  output logic                              day_stall,
  input  swsd_pkg::day_beat_t               day_data,
  output logic                              res_valid,
  input  logic                              res_stall,
  output swsd_pkg::res_beat_t               res_data,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [swsd_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);
  import swsd_pkg::*;

  localparam int RISE_W = ((Y_W > DY_W) ? Y_W : DY_W) + 2;
  localparam int CAP_W  = ((RISE_W > 19) ? RISE_W : 19) + 1;
  localparam int SUM_W  = 34;

  localparam logic signed [31:0]      HALF_FX    = 32'(ONE_FX / 2);
  localparam logic signed [31:0]      EXC_LO     = -32'(ONE_FX);
  localparam logic signed [31:0]      EXC_HI     = 32'sh7fff_ffff;
  localparam logic signed [SUM_W-1:0] SUM_LO     = -SUM_W'(ONE_FX);
  localparam logic signed [SUM_W-1:0] SUM_HI     = SUM_W'(EXC_HI);
  localparam logic [31:0]             EXC_RESET  = 32'(2 * ONE_FX);

  cfg_regs_t  cfg;
  rise_seg_t  seg;
  seq_state_t state;
  seq_state_t state_next;

  logic [MUL_W-1:0]     mul_a;
  logic [MUL_W-1:0]     mul_b;
  logic [2*MUL_W-1:0]   mul_p;

  day_beat_t            day;
  logic signed [31:0]   excess_store;
  logic [7:0]           run_count;
  logic [17:0]          evs;
  logic signed [31:0]   wexc1;
  logic [30:0]          seep;

  logic                 accept;
  logic                 load;
  logic signed [X_W-1:0] rise_x;

  logic [DY_W-1:0]          q;
  logic signed [RISE_W-1:0] rise;
  logic signed [CAP_W-1:0]  cap;
  logic signed [CAP_W-1:0]  es0_s;
  logic [17:0]              evs_next;
  logic signed [SUM_W-1:0]  sum;
  logic signed [31:0]       wexc1_next;
  logic [32:0]              seep_raw;
  logic [30:0]              seep_next;
  logic signed [31:0]       exc_new;
  logic                     workable;
  logic [7:0]               run_next;
  logic                     at_latest;
  logic                     sow;

  swsd_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // The deficit is only used when the excess is below one half, where it
  // fits the table's range.
  assign rise_x = X_W'(-excess_store);

  swsd_rise u_rise (
    .clk  (clk),
    .load (accept),
    .x    (rise_x),
    .seg  (seg)
  );

  swsd_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  assign day_stall = rst || (state != ST_IDLE);
  assign accept    = day_valid && !day_stall;
  assign load      = (state == ST_DONE) && !(res_valid && res_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    mul_a      = '0;
    mul_b      = '0;
    unique case (state)
      ST_IDLE: begin
        if (accept) state_next = ST_INTERP;
      end
      ST_INTERP: begin
        mul_a      = MUL_W'(seg.dx);
        mul_b      = MUL_W'(seg.dy);
        state_next = ST_DIVIDE;
      end
      ST_DIVIDE: begin
        // A falling segment needs a ceiling, so bias the dividend by d - 1.
        mul_a      = MUL_W'(mul_p[NUM_W-1:0]) + (seg.neg ? MUL_W'(seg.d_adj) : '0);
        mul_b      = MUL_W'(seg.recip);
        state_next = ST_EVAP;
      end
      ST_EVAP: begin
        state_next = ST_UPDATE;
      end
      ST_UPDATE: begin
        state_next = ST_SEEP_MUL;
      end
      ST_SEEP_MUL: begin
        mul_a      = MUL_W'(wexc1[30:0]);
        mul_b      = MUL_W'(cfg.seep_slope);
        state_next = ST_SEEP;
      end
      ST_SEEP: begin
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (load) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Evaporation: potential value on a wet layer, else capped by rise plus rain.
  always_comb begin
    q     = mul_p[DIV_SHIFT +: DY_W];
    rise  = seg.neg ? (RISE_W'(seg.y0) - RISE_W'(q)) : (RISE_W'(seg.y0) + RISE_W'(q));
    cap   = CAP_W'(rise) + CAP_W'(day.rainfall);
    es0_s = CAP_W'(day.potential_evap);
    if (excess_store >= HALF_FX) begin
      evs_next = day.potential_evap;
    end else if (cap < 0) begin
      evs_next = '0;
    end else if (es0_s < cap) begin
      evs_next = day.potential_evap;
    end else begin
      evs_next = cap[17:0];
    end
  end

  always_comb begin
    sum = SUM_W'(excess_store) + SUM_W'(day.rainfall) - SUM_W'(evs);
    if (sum < SUM_LO) begin
      wexc1_next = EXC_LO;
    end else if (sum > SUM_HI) begin
      wexc1_next = EXC_HI;
    end else begin
      wexc1_next = sum[31:0];
    end
  end

  always_comb begin
    seep_raw = 33'(mul_p[FRAC_BITS +: 32]) + 33'(cfg.seep_offset);
    if (wexc1 > 0) begin
      seep_next = (seep_raw > 33'(wexc1[30:0])) ? wexc1[30:0] : seep_raw[30:0];
    end else begin
      seep_next = '0;
    end
  end

  always_comb begin
    exc_new   = wexc1 - 32'(seep);
    workable  = exc_new <= 32'(cfg.deficit_limit);
    if (!workable) begin
      run_next = '0;
    end else if (run_count == 8'hff) begin
      run_next = run_count;
    end else begin
      run_next = run_count + 8'd1;
    end
    at_latest = day.day_index == cfg.latest_sow_day;
    sow       = ((day.day_index >= cfg.earliest_sow_day) && (run_next >= 8'd3)) || at_latest;
  end

  always_ff @(posedge clk) begin
    if (accept) day <= day_data;
    if (state == ST_EVAP) evs <= evs_next;
    if (state == ST_UPDATE) wexc1 <= wexc1_next;
    if (state == ST_SEEP) seep <= seep_next;
    if (load) begin
      res_data.soil_evap      <= evs;
      res_data.seepage        <= seep;
      res_data.excess_water   <= exc_new;
      res_data.workable_run   <= run_next;
      res_data.sow_now        <= sow;
      res_data.sown_at_latest <= sow && at_latest;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      excess_store <= EXC_RESET;
      run_count    <= '0;
      res_valid    <= 1'b0;
    end else begin
      if (load) begin
        excess_store <= exc_new;
        run_count    <= run_next;
        res_valid    <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  `SWSD_ASSERT(a_accept_starts, (day_valid && !day_stall) |=> (state == ST_INTERP))
  `SWSD_ASSERT(a_done_loads, (state == ST_DONE && !(res_valid && res_stall)) |=> (res_valid && state == ST_IDLE))
  `SWSD_ASSERT(a_state_hold, (state != ST_DONE) |=> ($stable(excess_store) && $stable(run_count)))
  `SWSD_ASSERT(a_seep_bound, (state == ST_DONE && wexc1 > 0) |-> (33'(seep) <= 33'(wexc1)))
  `SWSD_ASSERT(a_excess_floor, (state == ST_DONE) |-> (exc_new >= EXC_LO))

endmodule
